FILE: src/arpc_pkg.sv
// Shared types and constants for the ARP cache.
// No dependencies.
package arpc_pkg;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int OPC_W = 16;

    localparam logic [OPC_W-1:0] OPC_REQUEST = 16'd1;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef logic [IP_W-1:0]  ip_t;
    typedef logic [MAC_W-1:0] mac_t;

    // Per-cell control broadcast from the sequencer
    typedef struct packed {
        logic cmp;    // compare stored IP with key
        logic upd;    // overwrite MAC in the matching cell
        logic alloc;  // write key and MAC into the first free cell
    } arpc_ctl_t;

endpackage

FILE: src/arp_cache_learn_and_reply.sv
// ARP cache top level: sequencer, row of slot cells and match OR tree.
// Depends on arpc_pkg, arpc_cell, arpc_or_tree.
//
// Input channel s_*: valid/ready. kind 0 is a received ARP packet; the
// sender IP/MAC pair is learnt (MAC overwritten if the IP is known, else
// placed in the first free slot, or dropped with learn_dropped when full).
// An opcode of 1 produces reply fields. kind 1 looks query_ip up.
// Output channel m_*: valid/ready, exactly one transfer per input transfer.
// cfg_wr_en/cfg_wr_data set the interface MAC, used as reply source; write
// it only while the block is idle.
// Processing: the key is compared in parallel in every cell, the match flags
// and gated MACs pass through the registered OR tree, and a write-back step
// updates the table and loads the output register. Items are handled one at
// a time and the next transfer is taken in the cycle after write-back.
// A stalled receiver holds the finished item in the write-back step; the
// table is not updated until that result can be loaded.
// Synchronous reset clears all valid bits, the interface MAC and both
// channels' control state; no clearing pass is needed.
module arp_cache_learn_and_reply #(
    parameter int ENTRIES = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  arpc_pkg::mac_t         cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_kind,
    input  logic [15:0]            s_arp_opcode,
    input  arpc_pkg::mac_t         s_sender_mac,
    input  arpc_pkg::ip_t          s_sender_ip,
    input  arpc_pkg::ip_t          s_target_ip,
    input  arpc_pkg::ip_t          s_query_ip,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_send_reply,
    output arpc_pkg::mac_t         m_reply_dst_mac,
    output arpc_pkg::mac_t         m_reply_src_mac,
    output arpc_pkg::ip_t          m_reply_src_ip,
    output arpc_pkg::ip_t          m_reply_dst_ip,
    output logic                   m_lookup_hit,
    output arpc_pkg::mac_t         m_lookup_mac,
    output logic                   m_learn_dropped
);
    import arpc_pkg::*;

    localparam int L  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(L + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_TREE,
        S_WRITE
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    mac_t            iface_mac_reg;

    logic            kind_reg;
    logic            req_reg;
    ip_t             key_reg;
    mac_t            s_mac_reg;
    ip_t             t_ip_reg;

    logic            m_valid_reg;
    logic            send_reply_reg;
    mac_t            reply_dst_mac_reg;
    mac_t            reply_src_mac_reg;
    ip_t             reply_src_ip_reg;
    ip_t             reply_dst_ip_reg;
    logic            lookup_hit_reg;
    mac_t            lookup_mac_reg;
    logic            learn_dropped_reg;

    arpc_ctl_t       ctl;
    logic            fire;
    logic            is_packet;
    logic            root_hit;
    mac_t            root_mac;
    logic            full;
    logic [ENTRIES-1:0] cell_valid;
    logic [ENTRIES-1:0] cell_match;
    mac_t            cell_mac [ENTRIES];

    assign fire      = (state_reg == S_WRITE) && (!m_valid_reg || m_ready);
    assign is_packet = (kind_reg == KIND_PACKET);
    assign full      = cell_valid[ENTRIES-1];

    always_comb begin
        ctl.cmp   = (state_reg == S_CMP);
        ctl.upd   = fire && is_packet && root_hit;
        ctl.alloc = fire && is_packet && !root_hit;
    end

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic prev_valid;
        if (i == 0) begin : g_head
            assign prev_valid = 1'b1;
        end else begin : g_link
            assign prev_valid = cell_valid[i-1];
        end
        arpc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .key        (key_reg),
            .wr_mac     (s_mac_reg),
            .prev_valid (prev_valid),
            .valid_out  (cell_valid[i]),
            .match_out  (cell_match[i]),
            .mac_out    (cell_mac[i])
        );
    end

    arpc_or_tree #(
        .N (ENTRIES)
    ) u_tree (
        .aclk    (aclk),
        .hit_in  (cell_match),
        .mac_in  (cell_mac),
        .hit_out (root_hit),
        .mac_out (root_mac)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iface_mac_reg <= '0;
        end else if (cfg_wr_en) begin
            iface_mac_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        kind_reg  <= s_kind;
                        req_reg   <= (s_arp_opcode == OPC_REQUEST);
                        key_reg   <= (s_kind == KIND_LOOKUP) ? s_query_ip : s_sender_ip;
                        s_mac_reg <= s_sender_mac;
                        t_ip_reg  <= s_target_ip;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    cnt_reg   <= '0;
                    state_reg <= S_TREE;
                end
                S_TREE: begin
                    if (cnt_reg == CW'(L - 1)) begin
                        state_reg <= S_WRITE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_WRITE: begin
                    if (fire) begin
                        send_reply_reg    <= is_packet && req_reg;
                        reply_dst_mac_reg <= (is_packet && req_reg) ? s_mac_reg : '0;
                        reply_src_mac_reg <= (is_packet && req_reg) ? iface_mac_reg : '0;
                        reply_src_ip_reg  <= (is_packet && req_reg) ? t_ip_reg : '0;
                        reply_dst_ip_reg  <= (is_packet && req_reg) ? key_reg : '0;
                        lookup_hit_reg    <= !is_packet && root_hit;
                        lookup_mac_reg    <= (!is_packet && root_hit) ? root_mac : '0;
                        learn_dropped_reg <= is_packet && !root_hit && full;
                        state_reg         <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_send_reply    = send_reply_reg;
    assign m_reply_dst_mac = reply_dst_mac_reg;
    assign m_reply_src_mac = reply_src_mac_reg;
    assign m_reply_src_ip  = reply_src_ip_reg;
    assign m_reply_dst_ip  = reply_dst_ip_reg;
    assign m_lookup_hit    = lookup_hit_reg;
    assign m_lookup_mac    = lookup_mac_reg;
    assign m_learn_dropped = learn_dropped_reg;

endmodule

FILE: src/arpc_cell.sv
// One slot of the ARP cache: valid bit, IP, MAC and a registered match flag.
// Depends on arpc_pkg.
module arpc_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  arpc_pkg::arpc_ctl_t ctl,
    input  arpc_pkg::ip_t     key,
    input  arpc_pkg::mac_t    wr_mac,
    input  logic              prev_valid,
    output logic              valid_out,
    output logic              match_out,
    output arpc_pkg::mac_t    mac_out
);
    import arpc_pkg::*;

    logic valid_reg;
    logic match_reg;
    ip_t  ip_reg;
    mac_t mac_reg;
    logic first_free;

    // Slots fill in order, so the first free one follows a valid neighbour
    assign first_free = prev_valid && !valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.alloc && first_free) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.cmp) begin
            match_reg <= valid_reg && (ip_reg == key);
        end
        if (ctl.alloc && first_free) begin
            ip_reg  <= key;
            mac_reg <= wr_mac;
        end else if (ctl.upd && match_reg) begin
            mac_reg <= wr_mac;
        end
    end

    assign valid_out = valid_reg;
    assign match_out = match_reg;
    assign mac_out   = match_reg ? mac_reg : '0;

endmodule

FILE: src/arpc_or_tree.sv
// Registered binary OR tree that merges the cell match flags and gated MACs.
// Depends on arpc_pkg. Every level of the tree is registered.
module arpc_or_tree #(
    parameter int N = 64
) (
    input  logic              aclk,
    input  logic [N-1:0]      hit_in,
    input  arpc_pkg::mac_t    mac_in [N],
    output logic              hit_out,
    output arpc_pkg::mac_t    mac_out
);
    import arpc_pkg::*;

    localparam int L = (N > 1) ? $clog2(N) : 1;
    localparam int P = 1 << L;

    logic leaf_hit [P];
    mac_t leaf_mac [P];
    logic node_hit_reg [1:P-1];
    mac_t node_mac_reg [1:P-1];

    for (genvar j = 0; j < P; j++) begin : g_leaf
        if (j < N) begin : g_used
            assign leaf_hit[j] = hit_in[j];
            assign leaf_mac[j] = mac_in[j];
        end else begin : g_pad
            assign leaf_hit[j] = 1'b0;
            assign leaf_mac[j] = '0;
        end
    end

    for (genvar k = 1; k < P; k++) begin : g_node
        if (2 * k >= P) begin : g_bottom
            always_ff @(posedge aclk) begin
                node_hit_reg[k] <= leaf_hit[2*k-P] | leaf_hit[2*k+1-P];
                node_mac_reg[k] <= leaf_mac[2*k-P] | leaf_mac[2*k+1-P];
            end
        end else begin : g_inner
            always_ff @(posedge aclk) begin
                node_hit_reg[k] <= node_hit_reg[2*k] | node_hit_reg[2*k+1];
                node_mac_reg[k] <= node_mac_reg[2*k] | node_mac_reg[2*k+1];
            end
        end
    end

    assign hit_out = node_hit_reg[1];
    assign mac_out = node_mac_reg[1];

endmodule

FILE: src/arpc_checker.sv
// Port-level checks for the ARP cache, bound to the top level.
// Depends on arp_cache_learn_and_reply (bind target) and arpc_pkg.
module arpc_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  logic           m_valid,
    input  logic           m_ready,
    input  logic           m_send_reply,
    input  arpc_pkg::mac_t m_reply_dst_mac,
    input  logic           m_lookup_hit,
    input  arpc_pkg::mac_t m_lookup_mac,
    input  logic           m_learn_dropped
);

    // One item in flight: no transfer in the cycle after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lookup_mac)
            && $stable(m_reply_dst_mac) && $stable(m_send_reply))
        else $error("stalled result changed");

    // A lookup hit never carries reply or learning flags
    a_lookup_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lookup_hit |-> !m_send_reply && !m_learn_dropped)
        else $error("lookup hit mixed with packet fields");

    // Miss reports a zero MAC
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_lookup_hit |-> m_lookup_mac == '0)
        else $error("non-zero MAC on miss");

endmodule

bind arp_cache_learn_and_reply arpc_checker u_arpc_checker (.*);
